// ===== sv/dll_pkg.sv =====
// package: types, constants and request codes of the linked list engine
`default_nettype none
package dll_pkg;
	localparam int POOL_NODES = 64;
	localparam int DATA_BITS = 32;
	localparam int IDX_W = $clog2(POOL_NODES);
	localparam int LINK_W = IDX_W + 1;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_NODES);

	typedef enum logic [2:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_AFTER = 3'd1,
		REQ_INS_BACK  = 3'd2,
		REQ_DEL_FRONT = 3'd3,
		REQ_DEL_KEY   = 3'd4,
		REQ_DEL_BACK  = 3'd5,
		REQ_NOP6      = 3'd6,
		REQ_NOP7      = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DECIDE, S_SEARCH, S_SWAIT, S_NEXTRD, S_NEXTWT,
		S_LINK, S_UNRD, S_UNWT, S_UNLINK, S_HTRD, S_HTWT, S_DONE
	} state_t;

	// one node memory port access
	typedef struct packed {
		logic              en;
		logic              wr_data;
		logic              wr_next;
		logic              wr_prev;
		logic [IDX_W-1:0]  addr;
		logic [DATA_BITS-1:0] data;
		logic [LINK_W-1:0] next;
		logic [LINK_W-1:0] prev;
	} node_req_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] data;
		logic [LINK_W-1:0]    next;
		logic [LINK_W-1:0]    prev;
	} node_rd_t;
endpackage
`default_nettype wire

// ===== sv/dll_node_mem.sv =====
// node memory: data, next and prev words with one registered read port
`default_nettype none
module dll_node_mem (
	input  wire logic               clk,
	input  wire dll_pkg::node_req_t req,
	output dll_pkg::node_rd_t       rd
);
	logic [dll_pkg::DATA_BITS-1:0] data_mem [dll_pkg::POOL_NODES];
	logic [dll_pkg::LINK_W-1:0]    next_mem [dll_pkg::POOL_NODES];
	logic [dll_pkg::LINK_W-1:0]    prev_mem [dll_pkg::POOL_NODES];

	// write selected fields, read all fields
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.wr_data) data_mem[req.addr] <= req.data;
			if (req.wr_next) next_mem[req.addr] <= req.next;
			if (req.wr_prev) prev_mem[req.addr] <= req.prev;
			rd.data <= data_mem[req.addr];
			rd.next <= next_mem[req.addr];
			rd.prev <= prev_mem[req.addr];
		end
	end
endmodule
`default_nettype wire

// ===== sv/dll_free_stack.sv =====
// free index stack, loaded with every index by a fill pass after reset
`default_nettype none
module dll_free_stack (
	input  wire logic                      clk,
	input  wire logic                      push,
	input  wire logic                      pop,
	input  wire logic                      fill,
	input  wire logic [dll_pkg::IDX_W-1:0] addr,
	input  wire logic [dll_pkg::IDX_W-1:0] wdata,
	output logic [dll_pkg::IDX_W-1:0]      rdata
);
	logic [dll_pkg::IDX_W-1:0] stack_mem [dll_pkg::POOL_NODES];

	// one port: write on push or fill, read on pop
	always_ff @(posedge clk) begin
		if (push || fill) stack_mem[addr] <= wdata;
		if (pop) rdata <= stack_mem[addr];
	end
endmodule
`default_nettype wire

// ===== sv/doubly_linked_list_engine_top.sv =====
// top level: request sequencer of the linked list engine
// key requests (insert after, delete by key) walk the list from the head one node at a time,
// limited by the single node memory port
// throughput: one request at a time; input ready again the cycle after the result beat is taken
// reset: arst_n clears control; a fill pass over every free stack entry loads the free stack
// and no request is accepted until it ends
`default_nettype none
module doubly_linked_list_engine_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: req_type[2:0], value_in[34:3], key_value[66:35], zeros[71:67]
	input  wire logic [71:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: status[1:0], list_length[8:2], head_data[40:9], tail_data[72:41], zeros[79:73]
	output logic [79:0]      m_tdata
);
	localparam int IW = dll_pkg::IDX_W;
	localparam int LW = dll_pkg::LINK_W;
	localparam int DW = dll_pkg::DATA_BITS;

	dll_pkg::state_t state_q, state_d;
	dll_pkg::node_req_t nreq;
	dll_pkg::node_rd_t  nrd;

	logic [2:0]    kind_q;
	logic [DW-1:0] val_q, key_q;
	logic [LW-1:0] head_q, tail_q, cnt_q, free_q;
	logic [LW-1:0] cur_q, at_q, nb_q, newi_q, p_q, n_q;
	logic [LW-1:0] steps_q;
	logic [1:0]    status_q;
	logic [DW-1:0] head_d_q, tail_d_q;
	logic          out_v_q;
	logic          ht_phase_q;

	logic          fs_push, fs_pop, fs_fill;
	logic [IW-1:0] fs_addr, fs_wdata, fs_rdata;
	logic [IW-1:0] fill_q;

	dll_node_mem u_mem (.clk(clk), .req(nreq), .rd(nrd));
	dll_free_stack u_free (.clk(clk), .push(fs_push), .pop(fs_pop), .fill(fs_fill),
		.addr(fs_addr), .wdata(fs_wdata), .rdata(fs_rdata));

	logic accept;
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == dll_pkg::S_IDLE) && !out_v_q;

	function automatic logic [DW-1:0] cut_in(input logic [31:0] raw);
		return DW'($signed(raw));
	endfunction

	logic is_ins;
	assign is_ins = (kind_q == dll_pkg::REQ_INS_FRONT) || (kind_q == dll_pkg::REQ_INS_BACK)
		|| (kind_q == dll_pkg::REQ_INS_AFTER);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dll_pkg::S_INIT: if (fill_q == IW'(dll_pkg::POOL_NODES - 1)) state_d = dll_pkg::S_IDLE;
			dll_pkg::S_IDLE: if (accept) state_d = dll_pkg::S_DECIDE;
			dll_pkg::S_DECIDE: begin
				priority if (is_ins && free_q == '0) state_d = dll_pkg::S_HTRD;
				else if (kind_q == dll_pkg::REQ_INS_FRONT || kind_q == dll_pkg::REQ_INS_BACK)
					state_d = dll_pkg::S_LINK;
				else if (kind_q == dll_pkg::REQ_INS_AFTER || kind_q == dll_pkg::REQ_DEL_KEY)
					state_d = (head_q == dll_pkg::NIL) ? dll_pkg::S_HTRD : dll_pkg::S_SEARCH;
				else if (kind_q == dll_pkg::REQ_DEL_FRONT || kind_q == dll_pkg::REQ_DEL_BACK)
					state_d = (head_q == dll_pkg::NIL) ? dll_pkg::S_HTRD : dll_pkg::S_UNRD;
				else state_d = dll_pkg::S_HTRD;
			end
			dll_pkg::S_SEARCH: state_d = dll_pkg::S_SWAIT;
			dll_pkg::S_SWAIT: begin
				priority if (nrd.data == key_q)
					state_d = (kind_q == dll_pkg::REQ_INS_AFTER) ? dll_pkg::S_LINK
						: dll_pkg::S_UNLINK;
				else if (nrd.next == dll_pkg::NIL || steps_q == LW'(dll_pkg::POOL_NODES - 1))
					state_d = dll_pkg::S_HTRD;
				else state_d = dll_pkg::S_SEARCH;
			end
			dll_pkg::S_UNRD:   state_d = dll_pkg::S_UNWT;
			dll_pkg::S_UNWT:   state_d = dll_pkg::S_UNLINK;
			dll_pkg::S_LINK:   state_d = dll_pkg::S_NEXTRD;
			dll_pkg::S_UNLINK: state_d = dll_pkg::S_NEXTRD;
			dll_pkg::S_NEXTRD: state_d = dll_pkg::S_NEXTWT;
			dll_pkg::S_NEXTWT: state_d = dll_pkg::S_HTRD;
			dll_pkg::S_HTRD:   state_d = dll_pkg::S_HTWT;
			dll_pkg::S_HTWT:   state_d = ht_phase_q ? dll_pkg::S_DONE : dll_pkg::S_HTRD;
			dll_pkg::S_DONE:   state_d = dll_pkg::S_IDLE;
			default:           state_d = dll_pkg::S_IDLE;
		endcase
	end

	// memory and stack controls
	always_comb begin
		nreq = '0;
		fs_push = 1'b0;
		fs_pop = 1'b0;
		fs_fill = 1'b0;
		fs_addr = fill_q;
		fs_wdata = fill_q;
		unique case (state_q)
			dll_pkg::S_INIT: fs_fill = 1'b1;
			dll_pkg::S_DECIDE: begin
				// pop a free index early; only committed when linked
				fs_pop = 1'b1;
				fs_addr = IW'(free_q - LW'(1));
			end
			dll_pkg::S_SEARCH: begin
				nreq.en = 1'b1;
				nreq.addr = cur_q[IW-1:0];
			end
			dll_pkg::S_UNRD: begin
				nreq.en = 1'b1;
				nreq.addr = at_q[IW-1:0];
			end
			dll_pkg::S_LINK: begin
				// new node gets data and both links
				nreq.en = 1'b1;
				nreq.wr_data = 1'b1;
				nreq.wr_next = 1'b1;
				nreq.wr_prev = 1'b1;
				nreq.addr = fs_rdata;
				nreq.data = val_q;
				nreq.next = n_q;
				nreq.prev = p_q;
			end
			dll_pkg::S_UNLINK: begin
				// fix the next pointer of the predecessor and push the freed index onto the free stack
				if (p_q != dll_pkg::NIL) begin
					nreq.en = 1'b1;
					nreq.wr_next = 1'b1;
					nreq.addr = p_q[IW-1:0];
					nreq.next = n_q;
				end
				fs_push = 1'b1;
				fs_addr = free_q[IW-1:0];
				fs_wdata = at_q[IW-1:0];
			end
			dll_pkg::S_NEXTRD: begin
				// fix prev of the successor, on insert and on delete
				if (nb_q != dll_pkg::NIL) begin
					nreq.en = 1'b1;
					nreq.addr = nb_q[IW-1:0];
					if (is_ins) begin
						nreq.wr_prev = 1'b1;
						nreq.prev = newi_q;
					end else begin
						nreq.wr_prev = 1'b1;
						nreq.prev = p_q;
					end
				end
			end
			dll_pkg::S_NEXTWT: begin
				if (is_ins && p_q != dll_pkg::NIL) begin
					nreq.en = 1'b1;
					nreq.wr_next = 1'b1;
					nreq.addr = p_q[IW-1:0];
					nreq.next = newi_q;
				end
			end
			dll_pkg::S_HTRD: begin
				nreq.en = 1'b1;
				nreq.addr = ht_phase_q ? tail_q[IW-1:0] : head_q[IW-1:0];
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dll_pkg::S_INIT;
			fill_q <= '0;
			head_q <= dll_pkg::NIL;
			tail_q <= dll_pkg::NIL;
			cnt_q <= '0;
			free_q <= LW'(dll_pkg::POOL_NODES);
			out_v_q <= 1'b0;
			ht_phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dll_pkg::S_INIT) fill_q <= fill_q + IW'(1);
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				dll_pkg::S_LINK: begin
					free_q <= free_q - LW'(1);
					cnt_q <= cnt_q + LW'(1);
					if (p_q == dll_pkg::NIL) head_q <= {1'b0, fs_rdata};
					if (n_q == dll_pkg::NIL) tail_q <= {1'b0, fs_rdata};
				end
				dll_pkg::S_UNLINK: begin
					free_q <= free_q + LW'(1);
					cnt_q <= cnt_q - LW'(1);
					if (p_q == dll_pkg::NIL) head_q <= n_q;
					if (n_q == dll_pkg::NIL) tail_q <= p_q;
				end
				dll_pkg::S_HTWT: ht_phase_q <= ~ht_phase_q;
				dll_pkg::S_DONE: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			dll_pkg::S_IDLE: if (accept) begin
				kind_q <= s_tdata[2:0];
				val_q <= cut_in(s_tdata[34:3]);
				key_q <= cut_in(s_tdata[66:35]);
				status_q <= dll_pkg::ST_OK;
				cur_q <= head_q;
				steps_q <= '0;
			end
			dll_pkg::S_DECIDE: begin
				priority if (is_ins && free_q == '0) status_q <= dll_pkg::ST_FULL;
				else if ((kind_q == dll_pkg::REQ_INS_AFTER) && head_q == dll_pkg::NIL)
					status_q <= dll_pkg::ST_NOT_FOUND;
				else if ((kind_q == dll_pkg::REQ_DEL_KEY || kind_q == dll_pkg::REQ_DEL_FRONT
					|| kind_q == dll_pkg::REQ_DEL_BACK) && head_q == dll_pkg::NIL)
					status_q <= dll_pkg::ST_EMPTY;
				else status_q <= dll_pkg::ST_OK;
				// front/back link neighbours
				if (kind_q == dll_pkg::REQ_INS_FRONT) begin
					p_q <= dll_pkg::NIL;
					n_q <= head_q;
				end else begin
					p_q <= tail_q;
					n_q <= dll_pkg::NIL;
				end
				at_q <= (kind_q == dll_pkg::REQ_DEL_FRONT) ? head_q : tail_q;
			end
			dll_pkg::S_SWAIT: begin
				if (nrd.data == key_q) begin
					at_q <= cur_q;
					if (kind_q == dll_pkg::REQ_INS_AFTER) begin
						p_q <= cur_q;
						n_q <= nrd.next;
					end else begin
						p_q <= nrd.prev;
						n_q <= nrd.next;
					end
				end else if (nrd.next == dll_pkg::NIL ||
					steps_q == LW'(dll_pkg::POOL_NODES - 1)) begin
					status_q <= dll_pkg::ST_NOT_FOUND;
				end
				cur_q <= nrd.next;
				steps_q <= steps_q + LW'(1);
			end
			dll_pkg::S_UNWT: begin
				p_q <= nrd.prev;
				n_q <= nrd.next;
			end
			dll_pkg::S_LINK: begin
				newi_q <= {1'b0, fs_rdata};
				nb_q <= n_q;
			end
			dll_pkg::S_UNLINK: nb_q <= n_q;
			dll_pkg::S_HTWT: begin
				if (!ht_phase_q) head_d_q <= (head_q == dll_pkg::NIL) ? '0 : nrd.data;
				else tail_d_q <= (tail_q == dll_pkg::NIL) ? '0 : nrd.data;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {7'd0, 32'($signed(tail_d_q)), 32'($signed(head_d_q)), cnt_q, status_q};
endmodule
`default_nettype wire

// ===== sv/dll_checker.sv =====
// port checker for the linked list engine, bound to the top level
`default_nettype none
module dll_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata
);
	// no new request while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("request taken with result pending");
	// a result never follows acceptance at once
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !m_tvalid) else $error("result too early");
	// list length stays within the pool
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:2] <= 7'd64)) else $error("length out of range");
	// empty list reports zero head and tail
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[8:2] == 7'd0) |-> (m_tdata[72:9] == '0))
		else $error("empty list with data");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("result dropped");
endmodule

bind doubly_linked_list_engine_top dll_checker u_chk (.*);
`default_nettype wire
